FILE: rtl/csb_pkg.sv
// shared types and constants of the comment and string blanker
package csb_pkg;

    localparam int CHAR_W = 16;

    // result queue depth, must be a power of two and at least 2
    localparam int QDEPTH = 4;

    localparam logic [CHAR_W-1:0] CH_LF        = 16'd10;
    localparam logic [CHAR_W-1:0] CH_CR        = 16'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 16'd32;
    localparam logic [CHAR_W-1:0] CH_DQUOTE    = 16'd34;
    localparam logic [CHAR_W-1:0] CH_SQUOTE    = 16'd39;
    localparam logic [CHAR_W-1:0] CH_STAR      = 16'd42;
    localparam logic [CHAR_W-1:0] CH_SLASH     = 16'd47;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'd92;

    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_CODE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LINE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DQ    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SQ    = 3'd4;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              is_final;
    } src_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              out_final;
    } dst_req_t;

endpackage

FILE: rtl/comment_string_blanker.sv
// top level of the comment and string blanker: scanner state and result queue
//
// Blanks line comments, block comments and quoted literals (delimiters
// included) in a stream of 16-bit characters, keeping LF and CR, and gives
// one result per input character. A request is taken in every cycle in which
// the result queue holds at most two entries, so plain text flows at one
// character per cycle while dst_ready stays high; each result is registered
// in the result queue. A slash in code is held back until the next character
// arrives; that character then yields two results (the slash and itself, or
// two spaces when a comment opens), and the output side moves one result per
// cycle. The four-entry result queue lets the input side keep accepting while
// a result waits on the output, and a stalled output backs up into src_ready
// once more than two results are queued. The request marked is_final drains
// any held slash and returns the scanner to its reset state.
module comment_string_blanker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_ready,
    input  csb_pkg::src_req_t src,
    output logic              dst_valid,
    input  logic              dst_ready,
    output csb_pkg::dst_req_t dst
);

    localparam int PTR_W = $clog2(csb_pkg::QDEPTH);
    localparam int CNT_W = $clog2(csb_pkg::QDEPTH + 1);

    // scanner state
    logic [csb_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic                       slash_held_reg, slash_held_next;
    logic                       star_seen_reg, star_seen_next;
    logic                       escape_armed_reg, escape_armed_next;

    // result queue
    csb_pkg::dst_req_t queue_reg [csb_pkg::QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic accept;
    logic pop;

    // step results
    logic [1:0]                 push_n;
    logic [csb_pkg::CHAR_W-1:0] res0_char, res1_char;
    logic                       res0_final, res1_final;

    // character class and code-mode handling of the current character
    logic [csb_pkg::CHAR_W-1:0] c;
    logic                       fin;
    logic                       line_end;
    logic [csb_pkg::CHAR_W-1:0] blank_char;
    logic                       code_emit;
    logic [csb_pkg::CHAR_W-1:0] code_char;
    logic [csb_pkg::MODE_W-1:0] code_mode;
    logic                       code_hold;
    logic [csb_pkg::CHAR_W-1:0] quote_char;

    assign c          = src.char_in;
    assign fin        = src.is_final;
    assign line_end   = (c == csb_pkg::CH_LF) || (c == csb_pkg::CH_CR);
    assign blank_char = line_end ? c : csb_pkg::CH_SPACE;
    assign quote_char = (mode_reg == csb_pkg::MODE_DQ) ? csb_pkg::CH_DQUOTE
                                                       : csb_pkg::CH_SQUOTE;

    // handshake: room for the two results a request may cause
    assign src_ready = (count_reg <= CNT_W'(csb_pkg::QDEPTH - 2));
    assign accept    = src_valid && src_ready;
    assign dst_valid = (count_reg != '0);
    assign pop       = dst_valid && dst_ready;
    assign dst       = queue_reg[rd_ptr_reg];

    // a character seen in code mode
    always_comb
    begin
        code_emit = 1'b1;
        code_char = c;
        code_mode = csb_pkg::MODE_CODE;
        code_hold = 1'b0;
        if (c == csb_pkg::CH_SLASH)
        begin
            // hold back unless it is the last character
            if (!fin)
            begin
                code_emit = 1'b0;
                code_hold = 1'b1;
            end
        end
        else if (c == csb_pkg::CH_DQUOTE)
        begin
            code_mode = csb_pkg::MODE_DQ;
            code_char = csb_pkg::CH_SPACE;
        end
        else if (c == csb_pkg::CH_SQUOTE)
        begin
            code_mode = csb_pkg::MODE_SQ;
            code_char = csb_pkg::CH_SPACE;
        end
    end

    // one scanner step
    always_comb
    begin
        mode_next         = mode_reg;
        slash_held_next   = slash_held_reg;
        star_seen_next    = star_seen_reg;
        escape_armed_next = escape_armed_reg;
        push_n            = 2'd1;
        res0_char         = blank_char;
        res1_char         = blank_char;

        if (slash_held_reg)
        begin
            slash_held_next = 1'b0;
            if (c == csb_pkg::CH_SLASH)
            begin
                // line comment opens
                push_n    = 2'd2;
                res0_char = csb_pkg::CH_SPACE;
                res1_char = csb_pkg::CH_SPACE;
                mode_next = csb_pkg::MODE_LINE;
            end
            else if (c == csb_pkg::CH_STAR)
            begin
                // block comment opens, this star cannot close it
                push_n         = 2'd2;
                res0_char      = csb_pkg::CH_SPACE;
                res1_char      = csb_pkg::CH_SPACE;
                mode_next      = csb_pkg::MODE_BLOCK;
                star_seen_next = 1'b0;
            end
            else
            begin
                // plain slash, then the character handled as code
                push_n            = code_emit ? 2'd2 : 2'd1;
                res0_char         = csb_pkg::CH_SLASH;
                res1_char         = code_char;
                mode_next         = code_mode;
                slash_held_next   = code_hold;
                escape_armed_next = 1'b0;
            end
        end
        else
        begin
            case (mode_reg)
                csb_pkg::MODE_LINE:
                begin
                    if (line_end)
                    begin
                        mode_next = csb_pkg::MODE_CODE;
                    end
                end
                csb_pkg::MODE_BLOCK:
                begin
                    if (star_seen_reg && (c == csb_pkg::CH_SLASH))
                    begin
                        mode_next      = csb_pkg::MODE_CODE;
                        star_seen_next = 1'b0;
                    end
                    else
                    begin
                        star_seen_next = (c == csb_pkg::CH_STAR);
                    end
                end
                csb_pkg::MODE_DQ, csb_pkg::MODE_SQ:
                begin
                    if (escape_armed_reg)
                    begin
                        escape_armed_next = 1'b0;
                    end
                    else if (c == quote_char)
                    begin
                        mode_next = csb_pkg::MODE_CODE;
                        res0_char = csb_pkg::CH_SPACE;
                    end
                    else if (c == csb_pkg::CH_BACKSLASH)
                    begin
                        escape_armed_next = 1'b1;
                    end
                end
                default:
                begin
                    // code mode, unused codes fall here too
                    push_n            = code_emit ? 2'd1 : 2'd0;
                    res0_char         = code_char;
                    mode_next         = code_mode;
                    slash_held_next   = code_hold;
                    escape_armed_next = 1'b0;
                end
            endcase
        end

        // last character: flag the last result and clear the scanner
        res0_final = fin && (push_n == 2'd1);
        res1_final = fin;
        if (fin)
        begin
            mode_next         = csb_pkg::MODE_CODE;
            slash_held_next   = 1'b0;
            star_seen_next    = 1'b0;
            escape_armed_next = 1'b0;
        end
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
            count_next  = count_next + CNT_W'(push_n);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= csb_pkg::MODE_CODE;
            slash_held_reg   <= 1'b0;
            star_seen_reg    <= 1'b0;
            escape_armed_reg <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg         <= mode_next;
                slash_held_reg   <= slash_held_next;
                star_seen_reg    <= star_seen_next;
                escape_armed_reg <= escape_armed_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && (push_n != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= '{char_out: res0_char, out_final: res0_final};
        end
        if (accept && (push_n == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= '{char_out: res1_char, out_final: res1_final};
        end
    end

`ifndef SYNTHESIS
    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(csb_pkg::QDEPTH))
    else $error("result queue overflow");

    // a slash is only ever held in code mode
    assert property (@(posedge clk) disable iff (!rst_n)
        slash_held_reg |-> (mode_reg == csb_pkg::MODE_CODE))
    else $error("slash held outside code mode");

    // the last character leaves the scanner in its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && src.is_final) |=> ((mode_reg == csb_pkg::MODE_CODE)
            && !slash_held_reg && !star_seen_reg && !escape_armed_reg))
    else $error("scanner not cleared after last character");

    // a held slash always produces results on the next request
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && slash_held_reg) |=> (count_reg != '0))
    else $error("held slash dropped");
`endif

endmodule
